@@ sv/tmaq_pkg.sv @@
// ============================================================================
// Tile map autotile query package
// Shared constants, beat types and the character-to-class mapping.
// ============================================================================
package tmaq_pkg;

   // Grid size the cell store is built for
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = $clog2(DEPTH);

   // Compare width for coordinates and sizes: covers sizes up to 127 and
   // coordinates up to 127 plus one
   localparam int CMP_W = 10;

   // Configuration port
   localparam int CSR_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 1'b1;
   localparam logic [CSR_W-1:0]     CSR_SIZE_RESET = 7'd64;

   // Request actions
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // Map characters
   localparam logic [7:0] CHAR_RIGHT = 8'h3E;
   localparam logic [7:0] CHAR_LEFT  = 8'h3C;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Tile codes
   localparam logic [4:0] TILE_EMPTY = 5'd0;
   localparam logic [4:0] TILE_WALL  = 5'd1;
   localparam logic [4:0] TILE_RIGHT = 5'd16 + 5'd1;
   localparam logic [4:0] TILE_LEFT  = 5'd16 + 5'd2;

   // Stored cell classes
   typedef enum logic [1:0] {
      CLS_EMPTY = 2'd0,
      CLS_WALL  = 2'd1,
      CLS_RIGHT = 2'd2,
      CLS_LEFT  = 2'd3
   } cls_type;

   localparam int CLS_W = 2;

   typedef struct packed {
      logic              action;
      logic signed [7:0] col;
      logic signed [7:0] row;
      logic [7:0]        char_code;
   } req_type;

   typedef struct packed {
      logic [4:0] tile_code;
      logic       is_wall;
      logic       is_moveable;
      logic       in_range;
   } rsp_type;

   function automatic cls_type char_to_class(input logic [7:0] ch);
      cls_type cls;
      case (ch)
         CHAR_RIGHT: cls = CLS_RIGHT;
         CHAR_LEFT:  cls = CLS_LEFT;
         CHAR_SPACE: cls = CLS_EMPTY;
         default:    cls = CLS_WALL;
      endcase
      return cls;
   endfunction

endpackage

@@ sv/tile_map_autotile_query_unit.sv @@
// ============================================================================
// Tile map autotile query unit
// Grid store of tile classes with a four-neighbor autotile query.
// ============================================================================
//
//  channel   ports                           handshake
//  -------   ------------------------------  ------------------------------
//  request   start, busy, req_data           beat taken when start && !busy
//  response  rsp_valid, rsp_data             one-cycle strobe, no back-pressure
//  config    csr_we, csr_addr, csr_wdata     write taken when csr_we is high
//
//  A write beat occupies the unit while it is latched, then for one RAM write.
//  A query beat occupies it for five reads of the single-port cell RAM
//  (center, up, right, down, left) with registered read data, then the
//  result strobe; the next beat may be taken in the strobe cycle.
//  The single RAM port makes the reads run one after another.
//  Reset clears the sequencer and the size registers (both to 64); the cell
//  RAM is not cleared and a cell must be written before it is queried.
//  The receiver cannot stall: a result is shown for exactly one cycle.
//
module tile_map_autotile_query_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   start,
   output logic                                   busy,
   input  tmaq_pkg::req_type                      req_data,
   // response channel
   output logic                                   rsp_valid,
   output tmaq_pkg::rsp_type                      rsp_data,
   // configuration port
   input  logic                                   csr_we,
   input  logic [tmaq_pkg::CSR_IDX_W-1:0]         csr_addr,
   input  logic [tmaq_pkg::CSR_W-1:0]             csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WRITE,
      S_RD_C,
      S_RD_U,
      S_RD_R,
      S_RD_D,
      S_RD_L,
      S_DONE
   } state_type;

   localparam int CW = tmaq_pkg::CMP_W;
   localparam int AW = tmaq_pkg::ADDR_W;

   // -------------------------------------------------------------------------
   // Registers
   // -------------------------------------------------------------------------
   state_type                     state_ff, state_in;
   logic [tmaq_pkg::CSR_W-1:0]    map_width_ff;
   logic [tmaq_pkg::CSR_W-1:0]    map_height_ff;
   logic signed [7:0]             col_ff;
   logic signed [7:0]             row_ff;
   logic [7:0]                    char_ff;
   tmaq_pkg::cls_type             cls_c_ff, cls_c_in;
   logic [2:0]                    mask_ff, mask_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   tmaq_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   // -------------------------------------------------------------------------
   // Geometry of the latched cell
   // -------------------------------------------------------------------------
   logic [CW-1:0] eff_w, eff_h, width_ext, height_ext, col_ext, row_ext;
   logic          in_range, up_ok, right_ok, down_ok, left_ok;
   logic [AW-1:0] center_addr;

   assign width_ext  = CW'(map_width_ff);
   assign height_ext = CW'(map_height_ff);
   // clamp the size registers to the store's dimensions
   assign eff_w = (width_ext  > CW'(tmaq_pkg::MAX_WIDTH))  ? CW'(tmaq_pkg::MAX_WIDTH)  : width_ext;
   assign eff_h = (height_ext > CW'(tmaq_pkg::MAX_HEIGHT)) ? CW'(tmaq_pkg::MAX_HEIGHT) : height_ext;

   assign col_ext = {{(CW-8){1'b0}}, col_ff};
   assign row_ext = {{(CW-8){1'b0}}, row_ff};

   assign in_range = !col_ff[7] && !row_ff[7] && (col_ext < eff_w) && (row_ext < eff_h);

   // neighbor checks assume the center is in range
   assign up_ok    = (row_ff != 8'sd0);
   assign left_ok  = (col_ff != 8'sd0);
   assign right_ok = ((col_ext + CW'(1)) < eff_w);
   assign down_ok  = ((row_ext + CW'(1)) < eff_h);

   // fixed pitch: cell (col,row) sits at row*MAX_WIDTH+col
   assign center_addr = in_range
      ? AW'(row_ext) * AW'(tmaq_pkg::MAX_WIDTH) + AW'(col_ext)
      : '0;

   // -------------------------------------------------------------------------
   // Cell RAM
   // -------------------------------------------------------------------------
   logic                      ram_we;
   logic [AW-1:0]             ram_addr;
   logic [tmaq_pkg::CLS_W-1:0] ram_wdata, ram_rdata;
   logic                      rd_is_wall;

   assign ram_we    = (state_ff == S_WRITE) && in_range;
   assign ram_wdata = tmaq_pkg::CLS_W'(tmaq_pkg::char_to_class(char_ff));
   assign rd_is_wall = (ram_rdata == tmaq_pkg::CLS_WALL);

   // pick the address for this read slot; out-of-map neighbors reread center
   always_comb begin
      ram_addr = center_addr;
      case (state_ff)
         S_RD_U: if (up_ok)    ram_addr = center_addr - AW'(tmaq_pkg::MAX_WIDTH);
         S_RD_R: if (right_ok) ram_addr = center_addr + AW'(1);
         S_RD_D: if (down_ok)  ram_addr = center_addr + AW'(tmaq_pkg::MAX_WIDTH);
         S_RD_L: if (left_ok)  ram_addr = center_addr - AW'(1);
         default: ram_addr = center_addr;
      endcase
   end

   tmaq_ram #(
      .WIDTH (tmaq_pkg::CLS_W),
      .DEPTH (tmaq_pkg::DEPTH)
   ) u_cell_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // -------------------------------------------------------------------------
   // Sequencer: read data trails the address by one slot
   // -------------------------------------------------------------------------
   logic [3:0] full_mask;

   assign full_mask = {left_ok && rd_is_wall, mask_ff};

   always_comb begin
      state_in     = state_ff;
      cls_c_in     = cls_c_ff;
      mask_in      = mask_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = (req_data.action == tmaq_pkg::ACT_QUERY) ? S_RD_C : S_WRITE;
            end
         end
         S_WRITE: begin
            state_in = S_IDLE;
         end
         S_RD_C: begin
            state_in = S_RD_U;
         end
         S_RD_U: begin
            // center class arrives
            cls_c_in = tmaq_pkg::cls_type'(ram_rdata);
            state_in = S_RD_R;
         end
         S_RD_R: begin
            mask_in[0] = up_ok && rd_is_wall;
            state_in   = S_RD_D;
         end
         S_RD_D: begin
            mask_in[1] = right_ok && rd_is_wall;
            state_in   = S_RD_L;
         end
         S_RD_L: begin
            mask_in[2] = down_ok && rd_is_wall;
            state_in   = S_DONE;
         end
         S_DONE: begin
            // left neighbor arrives; form the result
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            if (in_range) begin
               rsp_data_in.in_range = 1'b1;
               case (cls_c_ff)
                  tmaq_pkg::CLS_WALL: begin
                     rsp_data_in.tile_code = tmaq_pkg::TILE_WALL + 5'(full_mask);
                     rsp_data_in.is_wall   = 1'b1;
                  end
                  tmaq_pkg::CLS_RIGHT: begin
                     rsp_data_in.tile_code   = tmaq_pkg::TILE_RIGHT;
                     rsp_data_in.is_moveable = 1'b1;
                  end
                  tmaq_pkg::CLS_LEFT: begin
                     rsp_data_in.tile_code   = tmaq_pkg::TILE_LEFT;
                     rsp_data_in.is_moveable = 1'b1;
                  end
                  default: begin
                     rsp_data_in.tile_code   = tmaq_pkg::TILE_EMPTY;
                     rsp_data_in.is_moveable = 1'b1;
                  end
               endcase
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         map_width_ff  <= tmaq_pkg::CSR_SIZE_RESET;
         map_height_ff <= tmaq_pkg::CSR_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               tmaq_pkg::CSR_MAP_WIDTH:  map_width_ff  <= csr_wdata;
               tmaq_pkg::CSR_MAP_HEIGHT: map_height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      // payload: hold the request beat while the item is in flight
      if (state_ff == S_IDLE && start) begin
         col_ff  <= req_data.col;
         row_ff  <= req_data.row;
         char_ff <= req_data.char_code;
      end
      cls_c_ff    <= cls_c_in;
      mask_ff     <= mask_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   a_query_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.action == tmaq_pkg::ACT_QUERY) |-> ##7 rsp_valid)
      else $error("query result did not arrive after seven cycles");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.action == tmaq_pkg::ACT_WRITE) |-> ##2 !rsp_valid)
      else $error("write beat produced a result");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_DONE))
      else $error("result strobe without a finished query");

   a_wall_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_wall) |->
         (rsp_data.in_range && rsp_data.tile_code != tmaq_pkg::TILE_EMPTY &&
          rsp_data.tile_code < tmaq_pkg::TILE_RIGHT))
      else $error("wall result with a bad tile code");

   a_out_of_range_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.in_range) |->
         (rsp_data.tile_code == tmaq_pkg::TILE_EMPTY && !rsp_data.is_wall &&
          !rsp_data.is_moveable))
      else $error("out-of-range result carries tile data");

endmodule

@@ sv/tmaq_ram.sv @@
// ============================================================================
// Tile map generic RAM
// Single-port synchronous RAM, read-first port, registered read data.
// ============================================================================
module tmaq_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[addr] <= wdata;
      end
      rd_data_ff <= store_ff[addr];
   end

   assign rdata = rd_data_ff;

endmodule
